>>> rtl/core/npcm_pkg.sv
package npcm_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int CH_W         = 8;
	localparam int IDX_W        = 8;
	localparam int SQ_W         = 2 * CH_W;
	localparam int DIST_W       = 18;
	localparam int RGB_W        = 3 * CH_W;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_MAP  = 1'b1;

	// One pipeline slot: the beat itself plus the running search result
	typedef struct packed {
		logic              valid;
		logic              func;
		logic [IDX_W-1:0]  entry_index;
		logic [CH_W-1:0]   red_value;
		logic [CH_W-1:0]   green_value;
		logic [CH_W-1:0]   blue_value;
		logic              frame_end;
		logic [DIST_W-1:0] cur_dist;
		logic [IDX_W-1:0]  lead_index;
		logic [DIST_W-1:0] best_dist;
	} pipe_t;

	function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
	endfunction

	function automatic logic [DIST_W-1:0] color_dist(input pipe_t p,
			input logic [RGB_W-1:0] rgb);
		logic [DIST_W-1:0] dr;
		logic [DIST_W-1:0] dg;
		logic [DIST_W-1:0] db;
		dr = DIST_W'(chan_sq(p.red_value,   rgb[3*CH_W-1:2*CH_W]));
		dg = DIST_W'(chan_sq(p.green_value, rgb[2*CH_W-1:CH_W]));
		db = DIST_W'(chan_sq(p.blue_value,  rgb[CH_W-1:0]));
		return dr + dg + db;
	endfunction

	// Fold the distance to the previous entry into the running best;
	// strict less-than keeps the lowest index on a tie
	function automatic pipe_t pipe_resolve(input pipe_t p,
			input logic [IDX_W-1:0] prev_index, input logic first);
		pipe_t r;
		r = p;
		if (first || (p.cur_dist < p.best_dist)) begin
			r.lead_index = prev_index;
			r.best_dist  = p.cur_dist;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/npcm_if.sv
interface npcm_in_if;
	import npcm_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [IDX_W-1:0] entry_index;
	logic [CH_W-1:0]  red_value;
	logic [CH_W-1:0]  green_value;
	logic [CH_W-1:0]  blue_value;
	logic             frame_end;

	modport source (output valid, func, entry_index, red_value, green_value, blue_value,
		frame_end, input ready);
	modport sink (input valid, func, entry_index, red_value, green_value, blue_value,
		frame_end, output ready);
endinterface

interface npcm_out_if;
	import npcm_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] palette_index;
	logic             frame_end_out;

	modport source (output valid, palette_index, frame_end_out, input ready);
	modport sink (input valid, palette_index, frame_end_out, output ready);
endinterface

>>> rtl/core/npcm_cell.sv
module npcm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [npcm_pkg::IDX_W-1:0] cell_index,
	input  npcm_pkg::pipe_t            slot_in,
	output npcm_pkg::pipe_t            slot_out
);
	import npcm_pkg::*;

	logic [RGB_W-1:0] entry_q;
	logic             valid_s1;
	pipe_t            data_s1;
	pipe_t            nxt;
	logic             first;
	logic             load_hit;

	// Resolve the previous entry's distance, measure against this entry
	assign first = (cell_index == IDX_W'(1));

	always_comb begin
		nxt          = pipe_resolve(slot_in, cell_index - IDX_W'(1), first);
		nxt.cur_dist = color_dist(slot_in, entry_q);
	end

	// Write this entry when a load beat for it passes through
	assign load_hit = en && slot_in.valid && (slot_in.func == FUNC_LOAD)
		&& (slot_in.entry_index == cell_index);

	always_ff @(posedge clk) begin
		if (load_hit) begin
			entry_q <= {slot_in.red_value, slot_in.green_value, slot_in.blue_value};
		end
	end

	// Advance the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= slot_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	always_comb begin
		slot_out       = data_s1;
		slot_out.valid = valid_s1;
	end

endmodule

>>> rtl/core/nearest_palette_color_mapper.sv
// Nearest palette color mapper.
// item (sink): func selects a load beat, which writes one palette entry at
//   entry_index with red/green/blue, or a map beat, which looks up one pixel.
// result (source): one beat per map beat, in order, with the index of the
//   nearest entry (squared RGB distance, lowest index on a tie) and the
//   pixel's frame_end. Load beats give no result.
// Throughput: one beat per cycle unless a stall holds the chain. Every palette
//   entry sits in its own cell of a systolic chain; a beat walks the chain,
//   one cell a cycle, and a load beat writes its entry as it passes, so maps
//   see exactly the loads before them. A beat is registered in the input slot,
//   in each cell and in the output register; the chain length sets the latency.
// Reset clears every valid bit; palette entries are undefined until loaded and
//   a map beat must not reach an entry never loaded.
// Stall: while a result waits and result.ready is low, the whole chain holds
//   and item.ready is low; nothing is lost or repeated.
module nearest_palette_color_mapper (
	input  logic       clk,
	input  logic       arst_n,
	npcm_in_if.sink    item,
	npcm_out_if.source result
);
	import npcm_pkg::*;

	logic             en;
	logic             valid_s0;
	pipe_t            data_s0;
	pipe_t            slot [0:PALETTE_SIZE];
	pipe_t            fin;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic             out_fe_q;
	logic [PALETTE_SIZE:0] slot_valid;

	// Advance the chain whenever the output register is free or drained
	assign en         = !out_valid_q || result.ready;
	assign item.ready = en;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s0.valid       <= item.valid;
			data_s0.func        <= item.func;
			data_s0.entry_index <= item.entry_index;
			data_s0.red_value   <= item.red_value;
			data_s0.green_value <= item.green_value;
			data_s0.blue_value  <= item.blue_value;
			data_s0.frame_end   <= item.frame_end;
			data_s0.cur_dist    <= '0;
			data_s0.lead_index  <= '0;
			data_s0.best_dist   <= '0;
		end
	end

	always_comb begin
		slot[0]       = data_s0;
		slot[0].valid = valid_s0;
	end

	// One cell per palette entry
	for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
		npcm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.cell_index (IDX_W'(k)),
			.slot_in    (slot[k]),
			.slot_out   (slot[k+1])
		);
	end

	for (genvar k = 0; k <= PALETTE_SIZE; k++) begin : g_valid
		assign slot_valid[k] = slot[k].valid;
	end

	// Fold in the last entry and register the result
	assign fin = pipe_resolve(slot[PALETTE_SIZE], IDX_W'(PALETTE_SIZE - 1), 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fin.valid && (fin.func == FUNC_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_index_q <= fin.lead_index;
			out_fe_q    <= fin.frame_end;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.palette_index = out_index_q;
	assign result.frame_end_out = out_fe_q;

	// A load beat leaving the chain never shows up as a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && slot[PALETTE_SIZE].valid && (slot[PALETTE_SIZE].func == FUNC_LOAD)
		|=> !out_valid_q)
		else $error("load beat produced a result");

	// A stall freezes every slot of the chain
	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(slot_valid))
		else $error("chain moved during a stall");

	// The reported index always names an existing entry
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, out_index_q} < (IDX_W + 1)'(PALETTE_SIZE)))
		else $error("palette index out of range");

endmodule

>>> test/tb_nearest_palette_color_mapper.sv
module tb_nearest_palette_color_mapper;
	import npcm_pkg::*;

	localparam int LATENCY      = PALETTE_SIZE + 2;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BEATS  = 380;
	localparam int NUM_PHASES   = 4;
	localparam int MAX_REPORTS  = 10;
	localparam int LOAD_PCT     = 20;

	// Expected index of a directed row: from the palette mirror, or typed in the row
	localparam logic CHECK_MIRROR = 1'b0;
	localparam logic CHECK_TYPED  = 1'b1;

	// Flow-control mix per phase: none, sender gaps, receiver stalls, both light
	localparam int PHASE_SRC_IDLE  [NUM_PHASES] = '{0, 86, 0, 9};
	localparam int PHASE_SNK_STALL [NUM_PHASES] = '{0, 0, 86, 9};

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] entry_index;
		logic [CH_W-1:0]  red_value;
		logic [CH_W-1:0]  green_value;
		logic [CH_W-1:0]  blue_value;
		logic             frame_end;
	} mapper_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0] palette_index;
		logic             frame_end_out;
	} lookup_t;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] entry_index;
		logic [CH_W-1:0]  red_value;
		logic [CH_W-1:0]  green_value;
		logic [CH_W-1:0]  blue_value;
		logic             frame_end;
		logic             check;
		logic [IDX_W-1:0] want;
	} step_row_t;

	// Palette starts as a gray ramp (entry i = i,i,i); rows then overwrite some entries
	localparam int NUM_ROWS = 21;
	localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// black and white land on the ends of the ramp
		'{FUNC_MAP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHECK_TYPED,  8'd0},
		'{FUNC_MAP,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, CHECK_TYPED,  8'd255},
		// entry_index of a map beat is ignored
		'{FUNC_MAP,  8'd255, 8'd10,  8'd10,  8'd10,  1'b0, CHECK_TYPED,  8'd10},
		// load with frame_end set gives no result; duplicate color, lower index wins
		'{FUNC_LOAD, 8'd5,   8'd10,  8'd10,  8'd10,  1'b1, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd10,  8'd10,  8'd10,  1'b0, CHECK_TYPED,  8'd5},
		'{FUNC_LOAD, 8'd250, 8'd0,   8'd0,   8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, CHECK_TYPED,  8'd0},
		'{FUNC_MAP,  8'd0,   8'd255, 8'd0,   8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		// primaries at the first, last and middle entries
		'{FUNC_LOAD, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd255, 8'd0,   8'd0,   1'b1, CHECK_TYPED,  8'd0},
		'{FUNC_LOAD, 8'd255, 8'd0,   8'd255, 8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd0,   8'd255, 8'd0,   1'b0, CHECK_TYPED,  8'd255},
		'{FUNC_LOAD, 8'd128, 8'd0,   8'd0,   8'd255, 1'b1, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0, CHECK_TYPED,  8'd128},
		'{FUNC_MAP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHECK_TYPED,  8'd250},
		// pixel halfway between two different colors: lower index wins
		'{FUNC_LOAD, 8'd2,   8'd100, 8'd0,   8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		'{FUNC_LOAD, 8'd3,   8'd102, 8'd0,   8'd0,   1'b0, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd101, 8'd0,   8'd0,   1'b1, CHECK_TYPED,  8'd2},
		'{FUNC_MAP,  8'd0,   8'd128, 8'd128, 8'd128, 1'b0, CHECK_TYPED,  8'd127},
		'{FUNC_MAP,  8'd0,   8'd170, 8'd85,  8'd42,  1'b1, CHECK_MIRROR, 8'd0},
		'{FUNC_MAP,  8'd0,   8'd255, 8'd255, 8'd0,   1'b0, CHECK_MIRROR, 8'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	npcm_in_if  item_bus ();
	npcm_out_if result_bus ();

	nearest_palette_color_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	logic [RGB_W-1:0] palette_mirror [PALETTE_SIZE];
	lookup_t          pending_lookups [$];

	int src_idle_pct    = 0;
	int snk_stall_pct   = 0;
	int fail_count      = 0;
	int cycle_count     = 0;
	int loads_sent      = 0;
	int maps_sent       = 0;
	int lookups_checked = 0;

	always #5 clk = ~clk;

	// Search the mirrored palette; strict less-than keeps the lowest index on a tie
	function automatic logic [IDX_W-1:0] nearest_entry_index(input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int               i;
		int               dr;
		int               dg;
		int               db;
		int               sq_sum;
		int               best_dist;
		logic [IDX_W-1:0] best;
		best      = '0;
		best_dist = 32'h7FFF_FFFF;
		for (i = 0; i < PALETTE_SIZE; i++) begin
			dr     = int'(r) - int'(palette_mirror[i][3*CH_W-1:2*CH_W]);
			dg     = int'(g) - int'(palette_mirror[i][2*CH_W-1:CH_W]);
			db     = int'(b) - int'(palette_mirror[i][CH_W-1:0]);
			sq_sum = dr * dr + dg * dg + db * db;
			if (sq_sum < best_dist) begin
				best_dist = sq_sum;
				best      = IDX_W'(i);
			end
		end
		return best;
	endfunction

	// Mostly pixels; colors are random, all-extreme channels, or a copy of a live entry
	function automatic mapper_beat_t random_beat();
		mapper_beat_t     b;
		logic [RGB_W-1:0] rgb;
		int               pick;
		b.func        = ($urandom_range(99) < LOAD_PCT) ? FUNC_LOAD : FUNC_MAP;
		b.entry_index = IDX_W'($urandom);
		b.red_value   = CH_W'($urandom);
		b.green_value = CH_W'($urandom);
		b.blue_value  = CH_W'($urandom);
		b.frame_end   = 1'($urandom);
		pick          = $urandom_range(3);
		if (pick == 0) begin
			rgb = palette_mirror[$urandom_range(PALETTE_SIZE - 1)];
			{b.red_value, b.green_value, b.blue_value} = rgb;
		end else if (pick == 1) begin
			b.red_value   = $urandom_range(1) ? {CH_W{1'b1}} : {CH_W{1'b0}};
			b.green_value = $urandom_range(1) ? {CH_W{1'b1}} : {CH_W{1'b0}};
			b.blue_value  = $urandom_range(1) ? {CH_W{1'b1}} : {CH_W{1'b0}};
		end
		return b;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	// Drive one beat, hold it until accepted, then update the mirror or queue the lookup
	task automatic send_beat(input mapper_beat_t b, input logic check,
			input logic [IDX_W-1:0] want);
		lookup_t exp;
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.func        <= b.func;
		item_bus.entry_index <= b.entry_index;
		item_bus.red_value   <= b.red_value;
		item_bus.green_value <= b.green_value;
		item_bus.blue_value  <= b.blue_value;
		item_bus.frame_end   <= b.frame_end;
		do @(posedge clk); while (!item_bus.ready);
		if (b.func == FUNC_LOAD) begin
			palette_mirror[b.entry_index] = {b.red_value, b.green_value, b.blue_value};
			loads_sent++;
		end else begin
			exp.palette_index = (check == CHECK_TYPED) ? want :
				nearest_entry_index(b.red_value, b.green_value, b.blue_value);
			exp.frame_end_out = b.frame_end;
			pending_lookups = {pending_lookups, exp};
			maps_sent++;
		end
	endtask

	// Check each result beat against the oldest pending lookup, then pick next ready
	always @(posedge clk) begin : result_monitor
		lookup_t exp;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			lookups_checked++;
			if (pending_lookups.size() == 0) begin
				log_failure($sformatf("unexpected result index %0d frame_end %0b",
					result_bus.palette_index, result_bus.frame_end_out));
			end else begin
				exp = pending_lookups.pop_front();
				if (result_bus.palette_index !== exp.palette_index ||
						result_bus.frame_end_out !== exp.frame_end_out)
					log_failure($sformatf(
						"expected index %0d frame_end %0b, got index %0d frame_end %0b",
						exp.palette_index, exp.frame_end_out,
						result_bus.palette_index, result_bus.frame_end_out));
			end
		end
		result_bus.ready <= arst_n ? ($urandom_range(99) >= snk_stall_pct) : 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_lookups.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		mapper_beat_t b;
		int           i;
		int           ph;
		arst_n               <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.func        <= FUNC_LOAD;
		item_bus.entry_index <= '0;
		item_bus.red_value   <= '0;
		item_bus.green_value <= '0;
		item_bus.blue_value  <= '0;
		item_bus.frame_end   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every entry before any lookup: gray ramp, highest entry first
		for (i = PALETTE_SIZE - 1; i >= 0; i--) begin
			b.func        = FUNC_LOAD;
			b.entry_index = IDX_W'(i);
			b.red_value   = CH_W'(i);
			b.green_value = CH_W'(i);
			b.blue_value  = CH_W'(i);
			b.frame_end   = 1'($urandom);
			send_beat(b, CHECK_MIRROR, '0);
		end

		// Walk the directed rows
		for (i = 0; i < NUM_ROWS; i++) begin
			b.func        = DIRECTED_ROWS[i].func;
			b.entry_index = DIRECTED_ROWS[i].entry_index;
			b.red_value   = DIRECTED_ROWS[i].red_value;
			b.green_value = DIRECTED_ROWS[i].green_value;
			b.blue_value  = DIRECTED_ROWS[i].blue_value;
			b.frame_end   = DIRECTED_ROWS[i].frame_end;
			send_beat(b, DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].want);
		end

		// Random traffic under each flow-control mix; drain the chain between phases
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			src_idle_pct  = PHASE_SRC_IDLE[ph];
			snk_stall_pct = PHASE_SNK_STALL[ph];
			for (i = 0; i < PHASE_BEATS; i++)
				send_beat(random_beat(), CHECK_MIRROR, '0);
			item_bus.valid <= 1'b0;
			do @(posedge clk); while (pending_lookups.size() != 0);
		end

		// Watch for stray results for more than a full pass through the chain
		snk_stall_pct = 0;
		repeat (LATENCY + 16) @(posedge clk);

		$display("Covered %0d palette writes and %0d pixel lookups (%0d results seen),",
			loads_sent, maps_sent, lookups_checked);
		$display("including ramp extremes, duplicate-color and equidistant ties, four stall mixes");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failures", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
